// ----- rtl/core/svpwm_min_max_injection_macros.svh -----
// ----------------------------------------------------------------------------
// SVPWM min-max injection: assertion macros
// Concurrent checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SVPWM_MIN_MAX_INJECTION_MACROS_SVH
`define SVPWM_MIN_MAX_INJECTION_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SVPWM_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("svpwm check failed");
// Consequent must hold in the cycle after the antecedent.
`define SVPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("svpwm check failed");
`else
`define SVPWM_ASSERT_HOLDS(label, ante, cons)
`define SVPWM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/svpwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM package
// Widths, constants and the divider step shared by the SVPWM datapath.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int unsigned IN_W      = 16;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 56;

    // sqrt(3)/2 in Q16, rounded
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;

    typedef logic [15:0] duty_t;
    localparam duty_t DUTY_HALF = 16'd16384;
    localparam duty_t DUTY_FULL = 16'd32768;

    typedef logic [2:0] sector_t;
    localparam sector_t SECTOR_NONE = 3'd0;
    localparam sector_t SECTOR_1    = 3'd1;
    localparam sector_t SECTOR_2    = 3'd2;
    localparam sector_t SECTOR_3    = 3'd3;
    localparam sector_t SECTOR_4    = 3'd4;
    localparam sector_t SECTOR_5    = 3'd5;
    localparam sector_t SECTOR_6    = 3'd6;

    localparam int unsigned KB_W    = 32;  // K * beta
    localparam int unsigned SQ_W    = 31;  // a * a, b * b
    localparam int unsigned PHASE_W = 33;  // phase reference, Q16
    localparam int unsigned DIFF_W  = 34;  // twice phase minus common mode
    localparam int unsigned NUM_W   = 32;  // rounded numerator over four
    localparam int unsigned DIV_W   = 15;  // quotient and remainder width

    localparam int unsigned DIV_STEPS_PER_STAGE = 3;
    localparam int unsigned DIV_STAGES          = DIV_W / DIV_STEPS_PER_STAGE;
    localparam int unsigned FRONT_STAGES        = 5;
    localparam int unsigned PIPE_STAGES         = FRONT_STAGES + DIV_STAGES;
    localparam int unsigned NUM_PHASES          = 3;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                                input logic nbit,
                                                input logic [DIV_W-1:0] dvs);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            return {1'b1, diff[DIV_W-1:0]};
        end
        return {1'b0, trial[DIV_W-1:0]};
    endfunction

endpackage

// ----- rtl/core/svpwm_min_max_injection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM min-max zero-sequence injection
// Alpha-beta voltage and bus voltage in, three clamped Q1.15 duties and the
// 60 degree sector out, one item per clock while m_axis is not stalled,
// through ten pipeline stages and an output register.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Data bits  Contents
//  s_axis    in         48         alpha, beta, bus voltage (signed 16 each)
//  m_axis    out        56         duty A, B, C (Q1.15), sector (3 bits)
//
// An item is accepted in every cycle while the pipeline has room; its result
// passes through every stage and the output register before it appears on
// m_axis. Half of the pipeline depth comes from the fifteen-bit restoring
// divider, which resolves three quotient bits per stage over five stages.
// aresetn is synchronous and active low; it empties every stage at once.
// A stall on m_axis holds the result and lets later items close up into any
// empty stages, so s_axis_tready only falls once every stage is occupied.
//
`include "svpwm_min_max_injection_macros.svh"

module svpwm_min_max_injection
    import svpwm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] alpha_voltage, [31:16] beta_voltage, [47:32] bus_voltage
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] duty_phase_a, [31:16] duty_phase_b, [47:32] duty_phase_c,
    // [50:48] sector_number, [55:51] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Flow control. Each stage loads when it is empty or when the stage
    // after it loads, so bubbles are squeezed out behind a stall.
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic                   m_valid_reg;
    logic [PIPE_STAGES:0]   en;

    always_comb begin
        en[PIPE_STAGES] = !m_valid_reg || m_axis_tready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = s_axis_tvalid;
        for (int k = 1; k < PIPE_STAGES; k++) begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int k = 0; k < PIPE_STAGES; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_next[k];
                end
            end
            if (en[PIPE_STAGES]) begin
                m_valid_reg <= vld_reg[PIPE_STAGES-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: products. K * beta for the inverse Clarke transform, and
    // the squares used by the sector test.
    // ------------------------------------------------------------------
    logic signed [IN_W-1:0] alpha_in;
    logic signed [IN_W-1:0] beta_in;
    logic signed [33:0]     kb_full;
    logic signed [31:0]     asq_full;
    logic signed [31:0]     bsq_full;

    logic signed [IN_W-1:0] mul_a_next, mul_a_reg;
    logic signed [IN_W-1:0] mul_bus_next, mul_bus_reg;
    logic signed [KB_W-1:0] mul_kb_next, mul_kb_reg;
    logic [SQ_W-1:0]        mul_asq_next, mul_asq_reg;
    logic [SQ_W-1:0]        mul_bsq_next, mul_bsq_reg;
    logic                   mul_bneg_next, mul_bneg_reg;
    logic                   mul_bzero_next, mul_bzero_reg;

    always_comb begin
        alpha_in       = s_axis_tdata[15:0];
        beta_in        = s_axis_tdata[31:16];
        kb_full        = $signed({1'b0, SQRT3_HALF_Q16}) * beta_in;
        asq_full       = alpha_in * alpha_in;
        bsq_full       = beta_in * beta_in;
        mul_a_next     = alpha_in;
        mul_bus_next   = s_axis_tdata[47:32];
        mul_kb_next    = kb_full[KB_W-1:0];
        mul_asq_next   = asq_full[SQ_W-1:0];
        mul_bsq_next   = bsq_full[SQ_W-1:0];
        mul_bneg_next  = beta_in[IN_W-1];
        mul_bzero_next = (beta_in == '0);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mul_a_reg     <= mul_a_next;
            mul_bus_reg   <= mul_bus_next;
            mul_kb_reg    <= mul_kb_next;
            mul_asq_reg   <= mul_asq_next;
            mul_bsq_reg   <= mul_bsq_next;
            mul_bneg_reg  <= mul_bneg_next;
            mul_bzero_reg <= mul_bzero_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: phase references in Q16, sector, bus check.
    // ------------------------------------------------------------------
    logic signed [PHASE_W-1:0] a_half;
    logic signed [PHASE_W-1:0] kb_ext;
    logic [PHASE_W-1:0]        a_sq3;
    logic [PHASE_W-1:0]        b_sq;
    logic                      a_neg;
    logic                      a_pos;

    logic signed [PHASE_W-1:0] ph_p_next [NUM_PHASES];
    logic signed [PHASE_W-1:0] ph_p_reg  [NUM_PHASES];
    sector_t                   ph_sector_next, ph_sector_reg;
    logic                      ph_bus_ok_next, ph_bus_ok_reg;
    logic [DIV_W-1:0]          ph_dvs_next, ph_dvs_reg;

    always_comb begin
        a_half       = {{2{mul_a_reg[IN_W-1]}}, mul_a_reg, 15'h0000};
        kb_ext       = {mul_kb_reg[KB_W-1], mul_kb_reg};
        ph_p_next[0] = {mul_a_reg[IN_W-1], mul_a_reg, 16'h0000};
        ph_p_next[1] = kb_ext - a_half;
        ph_p_next[2] = -a_half - kb_ext;

        // Sector from signs and beta^2 against 3 * alpha^2 (tan 60 squared).
        a_sq3 = {2'b00, mul_asq_reg} + {1'b0, mul_asq_reg, 1'b0};
        b_sq  = {2'b00, mul_bsq_reg};
        a_neg = mul_a_reg[IN_W-1];
        a_pos = !a_neg && (mul_a_reg != '0);
        if (mul_bzero_reg) begin
            ph_sector_next = a_neg ? SECTOR_4 : SECTOR_1;
        end else if (!mul_bneg_reg) begin
            if (a_pos && (b_sq < a_sq3)) begin
                ph_sector_next = SECTOR_1;
            end else if (!a_neg || (b_sq > a_sq3)) begin
                ph_sector_next = SECTOR_2;
            end else begin
                ph_sector_next = SECTOR_3;
            end
        end else begin
            if (a_neg && (b_sq < a_sq3)) begin
                ph_sector_next = SECTOR_4;
            end else if (!a_pos || (b_sq > a_sq3)) begin
                ph_sector_next = SECTOR_5;
            end else begin
                ph_sector_next = SECTOR_6;
            end
        end

        ph_bus_ok_next = !mul_bus_reg[IN_W-1] && (mul_bus_reg != '0);
        ph_dvs_next    = mul_bus_reg[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            ph_p_reg      <= ph_p_next;
            ph_sector_reg <= ph_sector_next;
            ph_bus_ok_reg <= ph_bus_ok_next;
            ph_dvs_reg    <= ph_dvs_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: maximum and minimum of the three references.
    // ------------------------------------------------------------------
    logic signed [PHASE_W-1:0] mx_ab, mn_ab;
    logic signed [PHASE_W-1:0] ext_p_reg [NUM_PHASES];
    logic signed [PHASE_W-1:0] ext_max_next, ext_max_reg;
    logic signed [PHASE_W-1:0] ext_min_next, ext_min_reg;
    sector_t                   ext_sector_reg;
    logic                      ext_bus_ok_reg;
    logic [DIV_W-1:0]          ext_dvs_reg;

    always_comb begin
        mx_ab        = (ph_p_reg[1] > ph_p_reg[0]) ? ph_p_reg[1] : ph_p_reg[0];
        mn_ab        = (ph_p_reg[1] < ph_p_reg[0]) ? ph_p_reg[1] : ph_p_reg[0];
        ext_max_next = (ph_p_reg[2] > mx_ab) ? ph_p_reg[2] : mx_ab;
        ext_min_next = (ph_p_reg[2] < mn_ab) ? ph_p_reg[2] : mn_ab;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            ext_p_reg      <= ph_p_reg;
            ext_max_reg    <= ext_max_next;
            ext_min_reg    <= ext_min_next;
            ext_sector_reg <= ph_sector_reg;
            ext_bus_ok_reg <= ph_bus_ok_reg;
            ext_dvs_reg    <= ph_dvs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: d = 2p - max - min, taken as (p - max) + (p - min).
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] dif_d_next [NUM_PHASES];
    logic signed [DIFF_W-1:0] dif_d_reg  [NUM_PHASES];
    sector_t                  dif_sector_reg;
    logic                     dif_bus_ok_reg;
    logic [DIV_W-1:0]         dif_dvs_reg;

    always_comb begin
        logic signed [DIFF_W-1:0] lo;
        logic signed [DIFF_W-1:0] hi;
        for (int l = 0; l < NUM_PHASES; l++) begin
            lo = {ext_p_reg[l][PHASE_W-1], ext_p_reg[l]}
               - {ext_max_reg[PHASE_W-1], ext_max_reg};
            hi = {ext_p_reg[l][PHASE_W-1], ext_p_reg[l]}
               - {ext_min_reg[PHASE_W-1], ext_min_reg};
            dif_d_next[l] = lo + hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            dif_d_reg      <= dif_d_next;
            dif_sector_reg <= ext_sector_reg;
            dif_bus_ok_reg <= ext_bus_ok_reg;
            dif_dvs_reg    <= ext_dvs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: rounded numerator. floor((|d| + 2 bus) / (4 bus)) equals
    // floor(floor((|d| + 2 bus) / 4) / bus), so the divider sees bus alone.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  num_m_next [NUM_PHASES];
    logic [NUM_W-1:0]  num_m_reg  [NUM_PHASES];
    logic              num_neg_next [NUM_PHASES];
    logic              num_neg_reg  [NUM_PHASES];
    sector_t           num_sector_reg;
    logic              num_bus_ok_reg;
    logic [DIV_W-1:0]  num_dvs_reg;

    always_comb begin
        logic signed [DIFF_W:0] dext;
        logic signed [DIFF_W:0] two_bus;
        logic signed [DIFF_W:0] sum;
        two_bus = {{(DIFF_W - DIV_W){1'b0}}, dif_dvs_reg, 1'b0};
        for (int l = 0; l < NUM_PHASES; l++) begin
            dext            = {dif_d_reg[l][DIFF_W-1], dif_d_reg[l]};
            num_neg_next[l] = dif_d_reg[l][DIFF_W-1];
            sum             = num_neg_next[l] ? (two_bus - dext) : (dext + two_bus);
            num_m_next[l]   = sum[NUM_W+1:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            num_m_reg      <= num_m_next;
            num_neg_reg    <= num_neg_next;
            num_sector_reg <= dif_sector_reg;
            num_bus_ok_reg <= dif_bus_ok_reg;
            num_dvs_reg    <= dif_dvs_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to 9: restoring divider, three quotient bits per stage.
    // A quotient of 2^15 or more saturates the duty either way, so the
    // first stage flags it and only fifteen quotient bits are resolved.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] div_rem_next  [DIV_STAGES][NUM_PHASES];
    logic [DIV_W-1:0] div_rem_reg   [DIV_STAGES][NUM_PHASES];
    logic [DIV_W-1:0] div_low_next  [DIV_STAGES][NUM_PHASES];
    logic [DIV_W-1:0] div_low_reg   [DIV_STAGES][NUM_PHASES];
    logic [DIV_W-1:0] div_quo_next  [DIV_STAGES][NUM_PHASES];
    logic [DIV_W-1:0] div_quo_reg   [DIV_STAGES][NUM_PHASES];
    logic             div_sat_next  [DIV_STAGES][NUM_PHASES];
    logic             div_sat_reg   [DIV_STAGES][NUM_PHASES];
    logic             div_neg_next  [DIV_STAGES][NUM_PHASES];
    logic             div_neg_reg   [DIV_STAGES][NUM_PHASES];
    logic [DIV_W-1:0] div_dvs_next  [DIV_STAGES];
    logic [DIV_W-1:0] div_dvs_reg   [DIV_STAGES];
    sector_t          div_sector_next [DIV_STAGES];
    sector_t          div_sector_reg  [DIV_STAGES];
    logic             div_bus_ok_next [DIV_STAGES];
    logic             div_bus_ok_reg  [DIV_STAGES];

    always_comb begin
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] low;
        logic [DIV_W-1:0] quo;
        logic [DIV_W:0]   step;
        logic [DIV_W-1:0] dvs;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                dvs                = num_dvs_reg;
                div_sector_next[s] = num_sector_reg;
                div_bus_ok_next[s] = num_bus_ok_reg;
            end else begin
                dvs                = div_dvs_reg[s-1];
                div_sector_next[s] = div_sector_reg[s-1];
                div_bus_ok_next[s] = div_bus_ok_reg[s-1];
            end
            div_dvs_next[s] = dvs;
            for (int l = 0; l < NUM_PHASES; l++) begin
                if (s == 0) begin
                    rem = num_m_reg[l][2*DIV_W-1:DIV_W];
                    low = num_m_reg[l][DIV_W-1:0];
                    quo = '0;
                    div_sat_next[s][l] =
                        (num_m_reg[l][NUM_W-1:DIV_W] >= {2'b00, dvs});
                    div_neg_next[s][l] = num_neg_reg[l];
                end else begin
                    rem = div_rem_reg[s-1][l];
                    low = div_low_reg[s-1][l];
                    quo = div_quo_reg[s-1][l];
                    div_sat_next[s][l] = div_sat_reg[s-1][l];
                    div_neg_next[s][l] = div_neg_reg[s-1][l];
                end
                for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
                    step = div_step(rem, low[DIV_W-1], dvs);
                    quo  = {quo[DIV_W-2:0], step[DIV_W]};
                    rem  = step[DIV_W-1:0];
                    low  = {low[DIV_W-2:0], 1'b0};
                end
                div_rem_next[s][l] = rem;
                div_low_next[s][l] = low;
                div_quo_next[s][l] = quo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (en[FRONT_STAGES + s]) begin
                div_rem_reg[s]    <= div_rem_next[s];
                div_low_reg[s]    <= div_low_next[s];
                div_quo_reg[s]    <= div_quo_next[s];
                div_sat_reg[s]    <= div_sat_next[s];
                div_neg_reg[s]    <= div_neg_next[s];
                div_dvs_reg[s]    <= div_dvs_next[s];
                div_sector_reg[s] <= div_sector_next[s];
                div_bus_ok_reg[s] <= div_bus_ok_next[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: duty = one half plus or minus the quotient, clamped
    // to 0..1. An invalid bus gives one half on every phase and sector 0.
    // ------------------------------------------------------------------
    duty_t   m_duty_next [NUM_PHASES];
    duty_t   m_duty_reg  [NUM_PHASES];
    sector_t m_sector_next, m_sector_reg;

    always_comb begin
        logic [DIV_W-1:0] q;
        logic             big;
        for (int l = 0; l < NUM_PHASES; l++) begin
            q   = div_quo_reg[DIV_STAGES-1][l];
            big = div_sat_reg[DIV_STAGES-1][l] || (q >= DUTY_HALF[DIV_W-1:0]);
            if (!div_bus_ok_reg[DIV_STAGES-1]) begin
                m_duty_next[l] = DUTY_HALF;
            end else if (div_neg_reg[DIV_STAGES-1][l]) begin
                m_duty_next[l] = big ? '0 : (DUTY_HALF - {1'b0, q});
            end else begin
                m_duty_next[l] = big ? DUTY_FULL : (DUTY_HALF + {1'b0, q});
            end
        end
        m_sector_next = div_bus_ok_reg[DIV_STAGES-1] ? div_sector_reg[DIV_STAGES-1]
                                                     : SECTOR_NONE;
    end

    always_ff @(posedge aclk) begin
        if (en[PIPE_STAGES]) begin
            m_duty_reg   <= m_duty_next;
            m_sector_reg <= m_sector_next;
        end
    end

    assign m_axis_tdata = {5'b00000, m_sector_reg,
                           m_duty_reg[2], m_duty_reg[1], m_duty_reg[0]};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SVPWM_ASSERT_HOLDS(a_neutral_duty, m_valid_reg && (m_sector_reg == SECTOR_NONE), (m_duty_reg[0] == DUTY_HALF) && (m_duty_reg[1] == DUTY_HALF) && (m_duty_reg[2] == DUTY_HALF))
    `SVPWM_ASSERT_HOLDS(a_duty_clamped, m_valid_reg, (m_duty_reg[0] <= DUTY_FULL) && (m_duty_reg[1] <= DUTY_FULL) && (m_duty_reg[2] <= DUTY_FULL))
    `SVPWM_ASSERT_HOLDS(a_stall_only_full, !s_axis_tready, (&vld_reg) && m_valid_reg && !m_axis_tready)
    `SVPWM_ASSERT_NEXT(a_last_stage_drains, vld_reg[PIPE_STAGES-1] && en[PIPE_STAGES], m_valid_reg)

endmodule
